/* rtl/core/ordered_array_list_engine_defines.svh */
// Assertion macros shared by the ordered array list engine.
`ifndef ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define OAL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ordered array list engine: assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define OAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ordered array list engine: assertion failed");

`endif

/* rtl/core/oal_pkg.sv */
// Package with sizes, codes and control types of the ordered array list engine.
`default_nettype none

package oal_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VAL_W  = 8;
    localparam int FUNC_W = 3;
    localparam int POS_W  = 7;
    localparam int STAT_W = 3;
    localparam int FI_W   = 6;
    localparam int LEN_W  = 7;
    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Search tree: groups of up to eight cells resolved in a first registered level.
    localparam int GROUP  = (DEPTH < 8) ? DEPTH : 8;
    localparam int NGROUP = (DEPTH + GROUP - 1) / GROUP;
    localparam int GL_W   = $clog2(GROUP);

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT    = 3'd0,
        FN_REMOVE_AT = 3'd1,
        FN_FIND_VAL  = 3'd2,
        FN_REMOVE_VAL = 3'd3,
        FN_WRITE_AT  = 3'd4,
        FN_READ_AT   = 3'd5,
        FN_CLEAR     = 3'd6
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_EMPTY    = 3'd2,
        STAT_BADPOS   = 3'd3,
        STAT_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MARK,
        S_GROUP,
        S_RESOLVE,
        S_APPLY
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_WRITE
    } t_cell_op;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic             mark;
        logic             by_value;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] target;
        logic [CNT_W-1:0] count;
        t_cell_op         op;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/core/ordered_array_list_engine.sv */
// Top level of the ordered array list engine: controller, cell row and search tree.
//
//   channel   direction  handshake                   payload
//   request   in         i_req_valid / o_req_ready   i_func, i_position, i_value
//   result    out        o_res_valid / i_res_ready   o_status, o_read_value,
//                                                    o_found_index, o_length,
//                                                    o_is_empty, o_is_full
//
// Each request goes through these steps from acceptance to the next acceptance:
// the cells register their hit flags, the registered priority tree resolves the
// first hit, the cells shift or write and the result register loads, and the
// block returns to idle, where the next request is taken.
// A result waits in its own register, so a new request is taken while it is
// still pending; a request whose result cannot load yet holds in its last step.
// Reset clears the length and the control state; the entries need no clearing.
`default_nettype none

module ordered_array_list_engine (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_req_valid,
    output logic                            o_req_ready,
    input  wire logic [oal_pkg::FUNC_W-1:0] i_func,
    input  wire logic [oal_pkg::POS_W-1:0]  i_position,
    input  wire logic [oal_pkg::VAL_W-1:0]  i_value,
    output logic                            o_res_valid,
    input  wire logic                       i_res_ready,
    output logic      [oal_pkg::STAT_W-1:0] o_status,
    output logic      [oal_pkg::VAL_W-1:0]  o_read_value,
    output logic      [oal_pkg::FI_W-1:0]   o_found_index,
    output logic      [oal_pkg::LEN_W-1:0]  o_length,
    output logic                            o_is_empty,
    output logic                            o_is_full
);
    import oal_pkg::*;
    `include "ordered_array_list_engine_defines.svh"

    t_state            r_state, n_state;
    logic [FUNC_W-1:0] r_func;
    logic [POS_W-1:0]  r_pos;
    logic [VAL_W-1:0]  r_val;
    logic [CNT_W-1:0]  r_count, n_count;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [VAL_W-1:0]  r_out_rd;
    logic [FI_W-1:0]   r_out_fidx;
    logic [CNT_W-1:0]  r_out_count;

    t_cell_ctl         ctl;
    t_status           stat;
    logic [VAL_W-1:0]  rd;
    logic [IDX_W-1:0]  fidx;
    logic              go;
    logic              accept;

    logic [VAL_W-1:0]  cell_entry [DEPTH];
    logic [VAL_W-1:0]  cell_data  [DEPTH];
    logic [DEPTH-1:0]  cell_hit;
    logic              pick_found;
    logic [IDX_W-1:0]  pick_index;
    logic [VAL_W-1:0]  pick_data;
    logic [CMP_W-1:0]  pos_x, cnt_x;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    // The last step may complete only when the result register is free.
    assign go          = (r_state == S_APPLY) && (!r_out_valid || i_res_ready);

    // The row of cells; the ends see zero beyond the row.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VAL_W-1:0] left_in, right_in;
        if (i == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_inner_l
            assign left_in = cell_entry[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_inner_r
            assign right_in = cell_entry[i+1];
        end
        oal_cell u_cell (
            .i_clk      (i_clk),
            .i_index    (IDX_W'(i)),
            .i_left     (left_in),
            .i_right    (right_in),
            .i_ctl      (ctl),
            .o_entry    (cell_entry[i]),
            .o_hit      (cell_hit[i]),
            .o_hit_data (cell_data[i])
        );
    end

    oal_pick u_pick (
        .i_clk   (i_clk),
        .i_hit   (cell_hit),
        .i_data  (cell_data),
        .o_found (pick_found),
        .o_index (pick_index),
        .o_data  (pick_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                n_state = S_GROUP;
            end
            S_GROUP: begin
                n_state = S_RESOLVE;
            end
            S_RESOLVE: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs of the controller: cell commands, status and the new length.
    always_comb begin
        pos_x        = CMP_W'(r_pos);
        cnt_x        = CMP_W'(r_count);
        ctl.mark     = 1'b0;
        ctl.by_value = (r_func inside {FN_FIND_VAL, FN_REMOVE_VAL});
        ctl.value    = r_val;
        ctl.target   = IDX_W'(r_pos);
        ctl.count    = r_count;
        ctl.op       = CELL_HOLD;
        stat         = STAT_OK;
        rd           = '0;
        fidx         = '0;
        n_count      = r_count;
        case (r_state)
            S_MARK: begin
                ctl.mark = 1'b1;
            end
            S_APPLY: begin
                case (r_func)
                    FN_INSERT: begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            stat = STAT_FULL;
                        end else if (pos_x > cnt_x) begin
                            stat = STAT_BADPOS;
                        end else begin
                            ctl.op  = CELL_SHIFT_UP;
                            n_count = r_count + 1'b1;
                        end
                    end
                    FN_REMOVE_AT, FN_WRITE_AT, FN_READ_AT: begin
                        if (r_count == '0) begin
                            stat = STAT_EMPTY;
                        end else if (pos_x >= cnt_x) begin
                            stat = STAT_BADPOS;
                        end else if (r_func == FN_REMOVE_AT) begin
                            ctl.op  = CELL_SHIFT_DOWN;
                            n_count = r_count - 1'b1;
                        end else if (r_func == FN_WRITE_AT) begin
                            ctl.op = CELL_WRITE;
                        end else begin
                            rd = pick_data;
                        end
                    end
                    FN_FIND_VAL, FN_REMOVE_VAL: begin
                        if (r_count == '0) begin
                            stat = STAT_EMPTY;
                        end else if (!pick_found) begin
                            stat = STAT_NOTFOUND;
                        end else begin
                            fidx       = pick_index;
                            ctl.target = pick_index;
                            if (r_func == FN_REMOVE_VAL) begin
                                ctl.op  = CELL_SHIFT_DOWN;
                                n_count = r_count - 1'b1;
                            end
                        end
                    end
                    FN_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        stat = STAT_OK;
                    end
                endcase
                if (!go) begin
                    ctl.op  = CELL_HOLD;
                    n_count = r_count;
                end
            end
            default: begin
                ctl.mark = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_pos  <= i_position;
            r_val  <= i_value;
        end
        if (go) begin
            r_out_status <= stat;
            r_out_rd     <= rd;
            r_out_fidx   <= FI_W'(fidx);
            r_out_count  <= n_count;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_read_value  = r_out_rd;
    assign o_found_index = r_out_fidx;
    assign o_length      = LEN_W'(r_out_count);
    assign o_is_empty    = (r_out_count == '0);
    assign o_is_full     = (r_out_count == CNT_W'(DEPTH));

    // The length never passes the capacity of the row.
    `OAL_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH))
    // The length moves only in the step that completes a request.
    `OAL_ASSERT_NEXT(a_count_stable, !go, $stable(r_count))
    // A completed request always leaves a pending result with the new length.
    `OAL_ASSERT_NEXT(a_result_loaded, go, r_out_valid && (r_out_count == r_count))

endmodule

`default_nettype wire

/* rtl/core/oal_cell.sv */
// One list cell: holds one entry, shifts with its neighbors and flags a search hit.
`default_nettype none

module oal_cell (
    input  wire logic                     i_clk,
    input  wire logic [oal_pkg::IDX_W-1:0] i_index,
    input  wire logic [oal_pkg::VAL_W-1:0] i_left,
    input  wire logic [oal_pkg::VAL_W-1:0] i_right,
    input  wire oal_pkg::t_cell_ctl        i_ctl,
    output logic      [oal_pkg::VAL_W-1:0] o_entry,
    output logic                           o_hit,
    output logic      [oal_pkg::VAL_W-1:0] o_hit_data
);
    import oal_pkg::*;

    logic [VAL_W-1:0] r_entry, n_entry;
    logic             r_hit, n_hit;
    logic [VAL_W-1:0] r_hit_data;
    logic             in_list, is_tgt, above;

    always_comb begin
        in_list = CNT_W'(i_index) < i_ctl.count;
        is_tgt  = (i_index == i_ctl.target);
        above   = (i_index > i_ctl.target);
        n_hit   = i_ctl.by_value ? (in_list && (r_entry == i_ctl.value)) : is_tgt;
        case (i_ctl.op)
            CELL_SHIFT_UP: begin
                n_entry = above ? i_left : (is_tgt ? i_ctl.value : r_entry);
            end
            CELL_SHIFT_DOWN: begin
                n_entry = (above || is_tgt) ? i_right : r_entry;
            end
            CELL_WRITE: begin
                n_entry = is_tgt ? i_ctl.value : r_entry;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctl.mark) begin
            r_hit      <= n_hit;
            r_hit_data <= n_hit ? r_entry : '0;
        end
    end

    assign o_entry    = r_entry;
    assign o_hit      = r_hit;
    assign o_hit_data = r_hit_data;

endmodule

`default_nettype wire

/* rtl/core/oal_pick.sv */
// Two-level registered priority tree that finds the first hit cell and its data.
`default_nettype none

module oal_pick (
    input  wire logic                      i_clk,
    input  wire logic [oal_pkg::DEPTH-1:0]  i_hit,
    input  wire logic [oal_pkg::VAL_W-1:0]  i_data [oal_pkg::DEPTH],
    output logic                            o_found,
    output logic      [oal_pkg::IDX_W-1:0]  o_index,
    output logic      [oal_pkg::VAL_W-1:0]  o_data
);
    import oal_pkg::*;

    logic             r_grp_any  [NGROUP];
    logic [GL_W-1:0]  r_grp_loc  [NGROUP];
    logic [VAL_W-1:0] r_grp_data [NGROUP];
    logic             n_grp_any  [NGROUP];
    logic [GL_W-1:0]  n_grp_loc  [NGROUP];
    logic [VAL_W-1:0] n_grp_data [NGROUP];

    logic             r_found, n_found;
    logic [IDX_W-1:0] r_index, n_index;
    logic [VAL_W-1:0] r_data, n_data;

    // First level: each group of cells resolves its own lowest hit.
    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            n_grp_any[g]  = 1'b0;
            n_grp_loc[g]  = '0;
            n_grp_data[g] = '0;
            for (int j = GROUP - 1; j >= 0; j--) begin
                if (g * GROUP + j < DEPTH) begin
                    if (i_hit[g * GROUP + j]) begin
                        n_grp_any[g] = 1'b1;
                        n_grp_loc[g] = GL_W'(j);
                    end
                    n_grp_data[g] = n_grp_data[g] | i_data[g * GROUP + j];
                end
            end
        end
    end

    // Second level: the lowest group that saw a hit wins.
    always_comb begin
        n_found = 1'b0;
        n_index = '0;
        n_data  = '0;
        for (int g = NGROUP - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                n_found = 1'b1;
                n_index = IDX_W'(g * GROUP) + IDX_W'(r_grp_loc[g]);
            end
            n_data = n_data | r_grp_data[g];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NGROUP; g++) begin
            r_grp_any[g]  <= n_grp_any[g];
            r_grp_loc[g]  <= n_grp_loc[g];
            r_grp_data[g] <= n_grp_data[g];
        end
        r_found <= n_found;
        r_index <= n_index;
        r_data  <= n_data;
    end

    assign o_found = r_found;
    assign o_index = r_index;
    assign o_data  = r_data;

endmodule

`default_nettype wire

/* test/ordered_array_list_engine_tb.sv */
// Self-checking testbench for the ordered array list engine: directed table, then random traffic.
`default_nettype none

module ordered_array_list_engine_tb;

    import oal_pkg::*;

    // Func code 7 is not part of the package enum; the block must treat it as a no-op.
    localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

    localparam int N_DIRECTED  = 25;
    localparam int N_RANDOM    = 1600;
    localparam int MAX_PRINTED = 50;

    // One result as the block reports it.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  read_value;
        logic [FI_W-1:0]   found_index;
        logic [LEN_W-1:0]  length;
        logic              is_empty;
        logic              is_full;
    } list_result_t;

    // One directed request. Where typed is set, the expected result is the one in the row.
    typedef struct packed {
        logic [FUNC_W-1:0] fn;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  val;
        logic              typed;
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  rd;
        logic [FI_W-1:0]   fi;
        logic [LEN_W-1:0]  len;
        logic              em;
        logic              fu;
    } directed_row_t;

    // The first rows run on an empty list, then a few entries are built up and worked on.
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{FN_READ_AT,    7'd0,   8'h00, 1'b1, STAT_EMPTY,    8'h00, 6'd0, 7'd0, 1'b1, 1'b0},
        '{FN_FIND_VAL,   7'd0,   8'h00, 1'b1, STAT_EMPTY,    8'h00, 6'd0, 7'd0, 1'b1, 1'b0},
        '{FN_REMOVE_AT,  7'd0,   8'h00, 1'b1, STAT_EMPTY,    8'h00, 6'd0, 7'd0, 1'b1, 1'b0},
        '{FN_REMOVE_VAL, 7'd0,   8'hFF, 1'b1, STAT_EMPTY,    8'h00, 6'd0, 7'd0, 1'b1, 1'b0},
        '{FN_WRITE_AT,   7'd0,   8'hFF, 1'b1, STAT_EMPTY,    8'h00, 6'd0, 7'd0, 1'b1, 1'b0},
        '{FN_CLEAR,      7'd0,   8'h00, 1'b1, STAT_OK,       8'h00, 6'd0, 7'd0, 1'b1, 1'b0},
        '{FN_INSERT,     7'd1,   8'h11, 1'b1, STAT_BADPOS,   8'h00, 6'd0, 7'd0, 1'b1, 1'b0},
        '{FN_INSERT,     7'd127, 8'h11, 1'b1, STAT_BADPOS,   8'h00, 6'd0, 7'd0, 1'b1, 1'b0},
        '{FN_INSERT,     7'd0,   8'hFF, 1'b1, STAT_OK,       8'h00, 6'd0, 7'd1, 1'b0, 1'b0},
        '{FN_INSERT,     7'd1,   8'h00, 1'b1, STAT_OK,       8'h00, 6'd0, 7'd2, 1'b0, 1'b0},
        '{FN_INSERT,     7'd0,   8'hA5, 1'b0, STAT_OK,       8'h00, 6'd0, 7'd0, 1'b0, 1'b0},
        '{FN_READ_AT,    7'd2,   8'h00, 1'b0, STAT_OK,       8'h00, 6'd0, 7'd0, 1'b0, 1'b0},
        '{FN_READ_AT,    7'd3,   8'h00, 1'b1, STAT_BADPOS,   8'h00, 6'd0, 7'd3, 1'b0, 1'b0},
        '{FN_READ_AT,    7'd127, 8'h00, 1'b1, STAT_BADPOS,   8'h00, 6'd0, 7'd3, 1'b0, 1'b0},
        '{FN_FIND_VAL,   7'd0,   8'h00, 1'b0, STAT_OK,       8'h00, 6'd0, 7'd0, 1'b0, 1'b0},
        '{FN_FIND_VAL,   7'd0,   8'h5A, 1'b1, STAT_NOTFOUND, 8'h00, 6'd0, 7'd3, 1'b0, 1'b0},
        '{FN_REMOVE_VAL, 7'd0,   8'h5A, 1'b1, STAT_NOTFOUND, 8'h00, 6'd0, 7'd3, 1'b0, 1'b0},
        '{FN_WRITE_AT,   7'd1,   8'h80, 1'b0, STAT_OK,       8'h00, 6'd0, 7'd0, 1'b0, 1'b0},
        '{FN_WRITE_AT,   7'd3,   8'h80, 1'b1, STAT_BADPOS,   8'h00, 6'd0, 7'd3, 1'b0, 1'b0},
        '{FN_REMOVE_AT,  7'd3,   8'h00, 1'b1, STAT_BADPOS,   8'h00, 6'd0, 7'd3, 1'b0, 1'b0},
        '{FN_REMOVE_AT,  7'd0,   8'h00, 1'b0, STAT_OK,       8'h00, 6'd0, 7'd0, 1'b0, 1'b0},
        '{FN_REMOVE_VAL, 7'd0,   8'h80, 1'b0, STAT_OK,       8'h00, 6'd0, 7'd0, 1'b0, 1'b0},
        '{FN_UNUSED,     7'd127, 8'hFF, 1'b0, STAT_OK,       8'h00, 6'd0, 7'd0, 1'b0, 1'b0},
        '{FN_CLEAR,      7'd0,   8'h00, 1'b1, STAT_OK,       8'h00, 6'd0, 7'd0, 1'b1, 1'b0},
        '{FN_READ_AT,    7'd0,   8'h00, 1'b1, STAT_EMPTY,    8'h00, 6'd0, 7'd0, 1'b1, 1'b0}
    };

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_req_valid = 1'b0;
    logic [FUNC_W-1:0] i_func      = '0;
    logic [POS_W-1:0]  i_position  = '0;
    logic [VAL_W-1:0]  i_value     = '0;
    logic              i_res_ready = 1'b0;
    logic              o_req_ready;
    logic              o_res_valid;
    logic [STAT_W-1:0] o_status;
    logic [VAL_W-1:0]  o_read_value;
    logic [FI_W-1:0]   o_found_index;
    logic [LEN_W-1:0]  o_length;
    logic              o_is_empty;
    logic              o_is_full;

    // Predicted copy of the list contents and its length.
    logic [VAL_W-1:0] list_mem [DEPTH];
    int               list_len = 0;

    // Results predicted for accepted requests, oldest first.
    list_result_t pending_results [$];

    int mismatch_count = 0;
    int send_idle_pct  = 30;   // per-cycle chance that the sender holds a request back
    int recv_idle_pct  = 48;   // per-cycle chance that the receiver is not ready
    int traffic_phase  = 0;    // 0 directed, 1..3 random with different idling
    logic stall_results = 1'b0;

    ordered_array_list_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .o_req_ready   (o_req_ready),
        .i_func        (i_func),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_found_index (o_found_index),
        .o_length      (o_length),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Hard limit on the run, far above the slowest legal run.
    initial begin
        #8000000;
        $display("ordered_array_list_engine_tb: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // Removes the entry at idx from the predicted list; later entries move down.
    function automatic void drop_entry(input int idx);
        for (int i = idx; i + 1 < list_len; i++) begin
            list_mem[i] = list_mem[i + 1];
        end
        list_len--;
    endfunction

    // Applies one request to the predicted list and returns the result it should give.
    function automatic list_result_t predict_list_op(input logic [FUNC_W-1:0] fn,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [VAL_W-1:0] val);
        list_result_t res;
        int p;
        int hit;
        res = '0;
        res.status = STAT_OK;
        p = int'(pos);
        hit = -1;
        case (fn)
            FN_INSERT: begin
                if (list_len >= DEPTH) begin
                    res.status = STAT_FULL;
                end else if (p > list_len) begin
                    res.status = STAT_BADPOS;
                end else begin
                    for (int i = list_len; i > p; i--) begin
                        list_mem[i] = list_mem[i - 1];
                    end
                    list_mem[p] = val;
                    list_len++;
                end
            end
            FN_REMOVE_AT, FN_WRITE_AT, FN_READ_AT: begin
                if (list_len == 0) begin
                    res.status = STAT_EMPTY;
                end else if (p >= list_len) begin
                    res.status = STAT_BADPOS;
                end else if (fn == FN_REMOVE_AT) begin
                    drop_entry(p);
                end else if (fn == FN_WRITE_AT) begin
                    list_mem[p] = val;
                end else begin
                    res.read_value = list_mem[p];
                end
            end
            FN_FIND_VAL, FN_REMOVE_VAL: begin
                if (list_len == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    for (int i = 0; i < list_len && hit < 0; i++) begin
                        if (list_mem[i] == val) hit = i;
                    end
                    if (hit < 0) begin
                        res.status = STAT_NOTFOUND;
                    end else begin
                        res.found_index = hit[FI_W-1:0];
                        if (fn == FN_REMOVE_VAL) drop_entry(hit);
                    end
                end
            end
            FN_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        res.length   = list_len[LEN_W-1:0];
        res.is_empty = (list_len == 0);
        res.is_full  = (list_len == DEPTH);
        return res;
    endfunction

    // Offers one request, holds it until accepted, then queues its expected result.
    // Called and returns right after a rising edge.
    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val, input logic typed,
                                input list_result_t typed_res);
        int gap;
        list_result_t predicted;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_func      <= fn;
        i_position  <= pos;
        i_value     <= val;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        predicted = predict_list_op(fn, pos, val);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Receiver: random backpressure, plus the long hold-off from the pressure process.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= !stall_results && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Once the sender runs without gaps, the receiver stops taking results for a long
    // stretch so the result register fills and the block has to stall its requests.
    initial begin
        wait (traffic_phase == 3);
        @(posedge i_clk);
        repeat ($urandom_range(20, 60)) @(posedge i_clk);
        stall_results <= 1'b1;
        repeat (400) @(posedge i_clk);
        stall_results <= 1'b0;
    end

    // Result checker: every accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        list_result_t exp_res;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, exp_res.status));
                if (o_read_value !== exp_res.read_value)
                    report_mismatch($sformatf("read_value %0h, expected %0h",
                                              o_read_value, exp_res.read_value));
                if (o_found_index !== exp_res.found_index)
                    report_mismatch($sformatf("found_index %0d, expected %0d",
                                              o_found_index, exp_res.found_index));
                if (o_length !== exp_res.length)
                    report_mismatch($sformatf("length %0d, expected %0d",
                                              o_length, exp_res.length));
                if (o_is_empty !== exp_res.is_empty)
                    report_mismatch($sformatf("is_empty %0b, expected %0b",
                                              o_is_empty, exp_res.is_empty));
                if (o_is_full !== exp_res.is_full)
                    report_mismatch($sformatf("is_full %0b, expected %0b",
                                              o_is_full, exp_res.is_full));
            end
        end
    end

    initial begin
        list_result_t      typed_res;
        logic [FUNC_W-1:0] fn;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  val;
        int                roll;
        bit                growing;
        growing = 1'b1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty-list errors, bad positions, append, not-found and the no-op code.
        for (int n = 0; n < N_DIRECTED; n++) begin
            typed_res.status      = DIRECTED_ROWS[n].status;
            typed_res.read_value  = DIRECTED_ROWS[n].rd;
            typed_res.found_index = DIRECTED_ROWS[n].fi;
            typed_res.length      = DIRECTED_ROWS[n].len;
            typed_res.is_empty    = DIRECTED_ROWS[n].em;
            typed_res.is_full     = DIRECTED_ROWS[n].fu;
            send_request(DIRECTED_ROWS[n].fn, DIRECTED_ROWS[n].pos, DIRECTED_ROWS[n].val,
                         DIRECTED_ROWS[n].typed, typed_res);
        end

        // Random part. The list alternates between growing towards full and shrinking
        // towards empty, so that full and empty both come up many times; most requests
        // use legal positions, searches mostly use values taken from the list, the rest is noise.
        typed_res = '0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 0) begin
                traffic_phase = 1;
            end else if (n == N_RANDOM / 3) begin
                traffic_phase = 2;
                send_idle_pct = 48;
                recv_idle_pct <= 30;
            end else if (n == 2 * N_RANDOM / 3) begin
                traffic_phase = 3;
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end

            if (growing && list_len == DEPTH && $urandom_range(9) == 0) growing = 1'b0;
            if (!growing && list_len == 0 && $urandom_range(2) == 0) growing = 1'b1;

            roll = $urandom_range(99);
            if (roll < 8) begin
                fn  = FUNC_W'($urandom_range(7));
                pos = POS_W'($urandom_range(127));
                val = VAL_W'($urandom_range(255));
            end else begin
                roll = $urandom_range(99);
                if (growing) begin
                    fn = (roll < 55) ? FN_INSERT :
                         (roll < 62) ? FN_REMOVE_AT :
                         (roll < 66) ? FN_REMOVE_VAL :
                         (roll < 76) ? FN_FIND_VAL :
                         (roll < 86) ? FN_WRITE_AT : FN_READ_AT;
                end else begin
                    fn = (roll < 15) ? FN_INSERT :
                         (roll < 45) ? FN_REMOVE_AT :
                         (roll < 65) ? FN_REMOVE_VAL :
                         (roll < 75) ? FN_FIND_VAL :
                         (roll < 85) ? FN_WRITE_AT :
                         (roll < 99) ? FN_READ_AT : FN_CLEAR;
                end
                if (fn == FN_INSERT) begin
                    pos = POS_W'($urandom_range(list_len));
                end else begin
                    pos = (list_len > 0) ? POS_W'($urandom_range(list_len - 1)) : '0;
                end
                // Searches mostly look for a value that is present.
                if ((fn == FN_FIND_VAL || fn == FN_REMOVE_VAL) && list_len > 0
                    && $urandom_range(9) < 7) begin
                    val = list_mem[IDX_W'($urandom_range(list_len - 1))];
                end else begin
                    val = VAL_W'($urandom_range(255));
                end
            end
            send_request(fn, pos, val, 1'b0, typed_res);
        end
        i_req_valid <= 1'b0;

        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("ordered_array_list_engine_tb: done, clean");
        end else begin
            $display("ordered_array_list_engine_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/oal_pkg.sv
rtl/core/oal_cell.sv
rtl/core/oal_pick.sv
rtl/core/ordered_array_list_engine.sv
test/ordered_array_list_engine_tb.sv
